@@ hdl/plt_pkg.sv @@
// Package for the peer learning table: payload structs, constants, codes.
// Used by every module under hdl; no dependencies.
package plt_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned OutCap     = 64;

  localparam logic [1:0] StRefreshed = 2'd0;
  localparam logic [1:0] StAdded     = 2'd1;
  localparam logic [1:0] StEvicted   = 2'd2;
  localparam logic [1:0] StIgnored   = 2'd3;

  localparam logic [1:0] RegFwdAddr  = 2'd0;
  localparam logic [1:0] RegFwdPort  = 2'd1;
  localparam logic [1:0] RegLearnEn  = 2'd2;
  localparam logic [1:0] RegAgeLimit = 2'd3;

  localparam logic ActLearn  = 1'b0;
  localparam logic ActFanout = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] now;
    logic [31:0] src_addr;
    logic [15:0] src_port;
  } in_item_t;

  typedef struct packed {
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic        peer_valid;
    logic [1:0]  learn_status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] seen;
  } entry_t;
endpackage

@@ hdl/peer_learning_table_with_aging_core.sv @@
// Peer learning table top level: config registers, sequencer, chain of cells.
// Depends on plt_pkg and plt_cell.
// The occupied cells form a ring that only ever looks at cell 0: each pass
// steps the ring once per entry, moving the head to the tail (kept) or
// dropping it, so a full pass restores table order. A learn transaction
// with learning enabled makes a match pass, then if no match a stale sweep
// that also finds the oldest entry, an eviction pass only when the table is
// still full, and an append step before the result step; a match goes
// straight to the result. With learning disabled a learn goes straight to
// an ignored result. A fan-out transaction makes one pass, which the output
// can stall; each listed peer is held back one step so last can be set.
// One transaction is in flight at a time; input is ready again once the
// final result is loaded into the output register.
module peer_learning_table_with_aging_core #(
  parameter int unsigned TABLE_DEPTH = plt_pkg::TableDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  plt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output plt_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = $clog2(plt_pkg::OutCap + 1);
  localparam logic [CW-1:0] Full = CW'(TABLE_DEPTH);
  localparam logic [EW-1:0] Cap  = EW'(plt_pkg::OutCap);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MATCH  = 7'b0000010,
    S_STALE  = 7'b0000100,
    S_EVICT  = 7'b0001000,
    S_APPEND = 7'b0010000,
    S_FAN    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] fwd_addr_q, age_q;
  logic [15:0] fwd_port_q;
  logic        learn_en_q;
  logic [CW-1:0] cnt_q, cnt_d, pos_q, pos_d, num_q, num_d;
  logic [CW-1:0] kept_q, kept_d, min_q, min_d;
  logic [31:0]   min_seen_q, min_seen_d;
  logic [EW-1:0] emitted_q, emitted_d;
  logic          found_q, found_d, hold_v_q, hold_v_d;
  logic [31:0]   hold_addr_q, hold_addr_d;
  logic [15:0]   hold_port_q, hold_port_d;
  plt_pkg::in_item_t  item_q;
  plt_pkg::out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;

  plt_pkg::entry_t ent [TABLE_DEPTH];
  plt_pkg::entry_t head, back_ent, new_ent;
  logic rot, drop, app, touch;
  logic busy, out_free, is_match, is_stale, is_fwd, fan_ok;
  logic [31:0] age;
  logic [TABLE_DEPTH-1:0] sh, bk, wr;

  assign new_ent = '{addr: item_q.src_addr, port: item_q.src_port, seen: item_q.now};

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    plt_pkg::entry_t up;
    if (g + 1 < TABLE_DEPTH) begin : g_up
      assign up = ent[g+1];
    end else begin : g_top
      assign up = ent[g];
    end
    assign sh[g] = (rot || drop) && (CW'(g + 1) < cnt_q);
    assign bk[g] = rot && (CW'(g + 1) == cnt_q);
    assign wr[g] = app && (CW'(g) == cnt_q);
    plt_cell u_cell (
      .clk_i    (clk_i),
      .up_i     (up),
      .back_i   (back_ent),
      .new_i    (new_ent),
      .shift_i  (sh[g]),
      .back_en_i(bk[g]),
      .wr_i     (wr[g]),
      .ent_o    (ent[g])
    );
  end

  assign head     = ent[0];
  assign busy     = pos_q < num_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign age      = item_q.now - head.seen;
  assign is_stale = age > age_q;
  assign is_match = head.addr == item_q.src_addr && head.port == item_q.src_port;
  assign is_fwd   = head.addr == fwd_addr_q && head.port == fwd_port_q;
  assign fan_ok   = !is_stale && !is_fwd && (emitted_q < Cap);

  always_comb begin
    back_ent = head;
    if (touch) back_ent.seen = item_q.now;
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; pos_d = pos_q; num_d = num_q;
    kept_d = kept_q; min_d = min_q; min_seen_d = min_seen_q;
    emitted_d = emitted_q; found_d = found_q; hold_v_d = hold_v_q;
    hold_addr_d = hold_addr_q; hold_port_d = hold_port_q;
    out_d = out_q; out_valid_d = out_valid_q; status_d = status_q;
    rot = 1'b0; drop = 1'b0; app = 1'b0; touch = 1'b0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pos_d = '0; num_d = cnt_q; found_d = 1'b0; hold_v_d = 1'b0; emitted_d = '0;
          if (in_data_i.action == plt_pkg::ActFanout) begin
            state_d = S_FAN;
          end else if (!learn_en_q) begin
            status_d = plt_pkg::StIgnored; state_d = S_OUT;
          end else begin
            state_d = S_MATCH;
          end
        end
      end
      S_MATCH: begin
        if (busy) begin
          rot = 1'b1; pos_d = pos_q + CW'(1);
          if (is_match && !found_q) begin
            touch = 1'b1; found_d = 1'b1;
          end
        end else if (found_q) begin
          status_d = plt_pkg::StRefreshed; state_d = S_OUT;
        end else begin
          pos_d = '0; num_d = cnt_q; kept_d = '0; state_d = S_STALE;
        end
      end
      S_STALE: begin
        if (busy) begin
          pos_d = pos_q + CW'(1);
          if (is_stale) begin
            drop = 1'b1; cnt_d = cnt_q - CW'(1);
          end else begin
            rot = 1'b1; kept_d = kept_q + CW'(1);
            if (kept_q == '0 || head.seen < min_seen_q) begin
              min_d = kept_q; min_seen_d = head.seen;
            end
          end
        end else if (cnt_q == Full) begin
          pos_d = '0; num_d = cnt_q; state_d = S_EVICT;
        end else begin
          status_d = plt_pkg::StAdded; state_d = S_APPEND;
        end
      end
      S_EVICT: begin
        if (busy) begin
          pos_d = pos_q + CW'(1);
          if (pos_q == min_q) begin
            drop = 1'b1; cnt_d = cnt_q - CW'(1);
          end else begin
            rot = 1'b1;
          end
        end else begin
          status_d = plt_pkg::StEvicted; state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        app = 1'b1; cnt_d = cnt_q + CW'(1); state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_d = '{peer_addr: '0, peer_port: '0, peer_valid: 1'b0,
                    learn_status: status_q, last: 1'b1};
          out_valid_d = 1'b1; state_d = S_IDLE;
        end
      end
      S_FAN: begin
        if (busy) begin
          // a qualifying head needs the output free to release the held peer
          if (!(fan_ok && hold_v_q && !out_free)) begin
            rot = 1'b1; pos_d = pos_q + CW'(1);
            if (fan_ok) begin
              if (hold_v_q) begin
                out_d = '{peer_addr: hold_addr_q, peer_port: hold_port_q, peer_valid: 1'b1,
                          learn_status: plt_pkg::StRefreshed, last: 1'b0};
                out_valid_d = 1'b1;
              end
              hold_addr_d = head.addr; hold_port_d = head.port; hold_v_d = 1'b1;
              emitted_d = emitted_q + EW'(1);
            end
          end
        end else if (out_free) begin
          if (hold_v_q) begin
            out_d = '{peer_addr: hold_addr_q, peer_port: hold_port_q, peer_valid: 1'b1,
                      learn_status: plt_pkg::StRefreshed, last: 1'b1};
          end else begin
            out_d = '{peer_addr: '0, peer_port: '0, peer_valid: 1'b0,
                      learn_status: plt_pkg::StRefreshed, last: 1'b1};
          end
          out_valid_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; out_valid_q <= 1'b0;
      fwd_addr_q <= '0; fwd_port_q <= '0; learn_en_q <= 1'b1; age_q <= 32'd60;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          plt_pkg::RegFwdAddr:  fwd_addr_q <= cfg_data_i;
          plt_pkg::RegFwdPort:  fwd_port_q <= cfg_data_i[15:0];
          plt_pkg::RegLearnEn:  learn_en_q <= cfg_data_i[0];
          plt_pkg::RegAgeLimit: age_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d; status_q <= status_d; pos_q <= pos_d; num_q <= num_d;
    kept_q <= kept_d; min_q <= min_d; min_seen_q <= min_seen_d;
    emitted_q <= emitted_d; found_q <= found_d; hold_v_q <= hold_v_d;
    hold_addr_q <= hold_addr_d; hold_port_q <= hold_port_d;
    if (state_q == S_IDLE && in_valid_i) item_q <= in_data_i;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Full)
    else $error("entry count overflow");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o))
    else $error("result changed while stalled");
  a_out_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");
`endif
endmodule

@@ hdl/plt_cell.sv @@
// One table slot of the cell ring: takes its neighbour's entry, the head
// entry coming round to the tail, or a new entry. Depends on plt_pkg.
module plt_cell (
  input  logic               clk_i,
  input  plt_pkg::entry_t    up_i,     // entry of the next cell
  input  plt_pkg::entry_t    back_i,   // head entry re-entering at the tail
  input  plt_pkg::entry_t    new_i,
  input  logic               shift_i,
  input  logic               back_en_i,
  input  logic               wr_i,
  output plt_pkg::entry_t    ent_o
);
  plt_pkg::entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (wr_i) begin
      ent_d = new_i;
    end else if (shift_i) begin
      ent_d = up_i;
    end else if (back_en_i) begin
      ent_d = back_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;
endmodule

@@ tb/peer_learning_table_with_aging_core_tb.sv @@
// Self-checking testbench for peer_learning_table_with_aging_core: directed rows, then random
// phases under five register settings, checked against an in-bench table predictor; typed
// directed rows check their listed result instead. Depends on plt_pkg and the RTL under hdl.
module peer_learning_table_with_aging_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchLimit = 6000;
  localparam int unsigned DrainWait  = 3 * plt_pkg::TableDepth + 8;
  localparam int unsigned PoolSize   = 96;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  plt_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  plt_pkg::out_item_t out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;

  peer_learning_table_with_aging_core dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  plt_pkg::entry_t    peers[plt_pkg::TableDepth];
  int unsigned        peer_cnt;
  logic [31:0]        fwd_addr = '0;
  logic [15:0]        fwd_port = '0;
  logic               learn_en = 1'b1;
  logic [31:0]        age_lim = 32'd60;
  plt_pkg::out_item_t pending_q[$];

  int unsigned n_fail = 0, n_learn = 0, n_fanout = 0, n_results = 0, n_evict = 0;
  int unsigned idle_cycles = 0;
  bit          burst = 0;

  function automatic void exp_push(plt_pkg::out_item_t r);
    pending_q = {pending_q, r};
  endfunction

  function automatic bit is_stale(plt_pkg::entry_t e, logic [31:0] now);
    logic [31:0] age;
    age = now - e.seen;
    return age > age_lim;
  endfunction

  function automatic logic [1:0] learn_peer(logic [31:0] now, logic [31:0] a, logic [15:0] p);
    int unsigned w, m;
    logic [1:0] st;
    for (int unsigned i = 0; i < peer_cnt; i++) begin
      if (peers[i].addr == a && peers[i].port == p) begin
        peers[i].seen = now;
        return plt_pkg::StRefreshed;
      end
    end
    w = 0;
    for (int unsigned i = 0; i < peer_cnt; i++) begin
      if (!is_stale(peers[i], now)) begin
        peers[w] = peers[i];
        w++;
      end
    end
    peer_cnt = w;
    st = plt_pkg::StAdded;
    if (peer_cnt >= plt_pkg::TableDepth) begin
      m = 0;
      for (int unsigned i = 1; i < peer_cnt; i++)
        if (peers[i].seen < peers[m].seen) m = i;
      for (int unsigned i = m; i + 1 < peer_cnt; i++) peers[i] = peers[i + 1];
      peer_cnt--;
      st = plt_pkg::StEvicted;
    end
    peers[peer_cnt] = '{addr: a, port: p, seen: now};
    peer_cnt++;
    return st;
  endfunction

  function automatic void predict_item(plt_pkg::in_item_t it);
    plt_pkg::out_item_t r;
    int unsigned k;
    if (it.action == plt_pkg::ActLearn) begin
      n_learn++;
      r = '0;
      r.last = 1'b1;
      r.learn_status = learn_en ? learn_peer(it.now, it.src_addr, it.src_port)
                                : plt_pkg::StIgnored;
      if (r.learn_status == plt_pkg::StEvicted) n_evict++;
      exp_push(r);
    end else begin
      n_fanout++;
      k = 0;
      for (int unsigned i = 0; i < peer_cnt && k < plt_pkg::OutCap; i++) begin
        if (is_stale(peers[i], it.now)) continue;
        if (peers[i].addr == fwd_addr && peers[i].port == fwd_port) continue;
        r = '0;
        r.peer_addr  = peers[i].addr;
        r.peer_port  = peers[i].port;
        r.peer_valid = 1'b1;
        exp_push(r);
        k++;
      end
      if (k == 0) begin
        r = '0;
        r.last = 1'b1;
        exp_push(r);
      end else begin
        pending_q[pending_q.size() - 1].last = 1'b1;
      end
    end
  endfunction

  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(plt_pkg::in_item_t it, bit typed, plt_pkg::out_item_t texp);
    int g;
    int unsigned base;
    g = burst ? 0 : gap_len();
    repeat (g) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    base = pending_q.size();
    predict_item(it);
    if (typed) begin
      while (pending_q.size() > base) void'(pending_q.pop_back());
      exp_push(texp);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      plt_pkg::RegFwdAddr:  fwd_addr = val;
      plt_pkg::RegFwdPort:  fwd_port = val[15:0];
      plt_pkg::RegLearnEn:  learn_en = val[0];
      plt_pkg::RegAgeLimit: age_lim  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result side: random back-pressure
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (!burst && $urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    plt_pkg::out_item_t e;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("peer_learning_table_with_aging_core: mismatch");
        $finish;
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction %p", out_data_o);
        n_fail++;
      end else begin
        e = pending_q.pop_front();
        if (out_data_o.peer_addr !== e.peer_addr) begin
          $error("peer_addr: expected %h, got %h", e.peer_addr, out_data_o.peer_addr);
          n_fail++;
        end
        if (out_data_o.peer_port !== e.peer_port) begin
          $error("peer_port: expected %h, got %h", e.peer_port, out_data_o.peer_port);
          n_fail++;
        end
        if (out_data_o.peer_valid !== e.peer_valid) begin
          $error("peer_valid: expected %b, got %b", e.peer_valid, out_data_o.peer_valid);
          n_fail++;
        end
        if (out_data_o.learn_status !== e.learn_status) begin
          $error("learn_status: expected %0d, got %0d", e.learn_status,
                 out_data_o.learn_status);
          n_fail++;
        end
        if (out_data_o.last !== e.last) begin
          $error("last: expected %b, got %b", e.last, out_data_o.last);
          n_fail++;
        end
      end
    end
  end

  typedef struct {
    logic        act;
    logic [31:0] now;
    logic [31:0] addr;
    logic [15:0] port;
    bit          typed;
    logic [1:0]  st;
  } dir_row_t;

  dir_row_t dir_rows[15] = '{
    '{plt_pkg::ActFanout, 32'd0,        32'h0,        16'h0,    1, plt_pkg::StRefreshed},
    '{plt_pkg::ActLearn,  32'd0,        32'h0,        16'h0,    1, plt_pkg::StAdded},
    '{plt_pkg::ActFanout, 32'd0,        32'h0,        16'h0,    1, plt_pkg::StRefreshed},
    '{plt_pkg::ActLearn,  32'd10,       32'hFFFFFFFF, 16'hFFFF, 1, plt_pkg::StAdded},
    '{plt_pkg::ActLearn,  32'd20,       32'hFFFFFFFF, 16'hFFFF, 1, plt_pkg::StRefreshed},
    '{plt_pkg::ActFanout, 32'd20,       32'h0,        16'h0,    0, plt_pkg::StRefreshed},
    '{plt_pkg::ActLearn,  32'd70,       32'hA5A5A5A5, 16'h5A5A, 1, plt_pkg::StAdded},
    '{plt_pkg::ActFanout, 32'd80,       32'hFFFFFFFF, 16'hFFFF, 0, plt_pkg::StRefreshed},
    '{plt_pkg::ActFanout, 32'd81,       32'h0,        16'h0,    0, plt_pkg::StRefreshed},
    '{plt_pkg::ActLearn,  32'hFFFFFFF0, 32'h12345678, 16'h1234, 1, plt_pkg::StAdded},
    '{plt_pkg::ActLearn,  32'd5,        32'h87654321, 16'h4321, 1, plt_pkg::StAdded},
    '{plt_pkg::ActFanout, 32'd10,       32'h0,        16'h0,    0, plt_pkg::StRefreshed},
    '{plt_pkg::ActFanout, 32'hFFFFFFFF, 32'h0,        16'h0,    0, plt_pkg::StRefreshed},
    '{plt_pkg::ActLearn,  32'hFFFFFFFF, 32'h0,        16'hFFFF, 1, plt_pkg::StAdded},
    '{plt_pkg::ActFanout, 32'hFFFFFFFF, 32'h0,        16'h0,    0, plt_pkg::StRefreshed}
  };

  logic [31:0] pool_addr[PoolSize];
  logic [15:0] pool_port[PoolSize];

  initial begin
    plt_pkg::in_item_t  it;
    plt_pkg::out_item_t te;
    logic [31:0] t_now;
    int unsigned sel;
    logic [31:0] ph_age[5];
    logic [31:0] ph_fwd_a[5];
    logic [15:0] ph_fwd_p[5];
    logic        ph_en[5];

    peer_cnt = 0;
    for (int i = 0; i < PoolSize; i++) begin
      pool_addr[i] = $urandom();
      pool_port[i] = $urandom_range(0, 16'hFFFF);
    end
    pool_addr[0] = '0;
    pool_port[0] = '0;
    pool_addr[1] = '1;
    pool_port[1] = '1;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      it = '{action: dir_rows[i].act, now: dir_rows[i].now,
             src_addr: dir_rows[i].addr, src_port: dir_rows[i].port};
      te = '0;
      te.last = 1'b1;
      te.learn_status = dir_rows[i].st;
      send_item(it, dir_rows[i].typed, te);
    end

    ph_age   = '{32'd60, 32'hFFFFFFFF, 32'd0, 32'd40, 32'd1000};
    ph_fwd_a = '{32'h0, pool_addr[1], pool_addr[2], 32'hFFFFFFFF, pool_addr[3]};
    ph_fwd_p = '{16'h0, pool_port[1], pool_port[2], 16'hFFFF, pool_port[3]};
    ph_en    = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

    t_now = 32'hFFFFFF00;
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      write_reg(plt_pkg::RegAgeLimit, ph_age[ph]);
      write_reg(plt_pkg::RegFwdAddr, ph_fwd_a[ph]);
      write_reg(plt_pkg::RegFwdPort, {16'h0, ph_fwd_p[ph]});
      write_reg(plt_pkg::RegLearnEn, {31'h0, ph_en[ph]});
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(0, 29) == 0) burst = !burst;
        sel = $urandom_range(0, 99);
        if (sel < 70)      t_now = t_now + $urandom_range(0, 3);
        else if (sel < 95) t_now = t_now + $urandom_range(0, 90);
        else               t_now = $urandom();
        it.action = ($urandom_range(0, 99) < 70) ? plt_pkg::ActLearn : plt_pkg::ActFanout;
        it.now = t_now;
        if ($urandom_range(0, 99) < 85) begin
          sel = $urandom_range(0, PoolSize - 1);
          it.src_addr = pool_addr[sel];
          it.src_port = pool_port[sel];
        end else begin
          it.src_addr = $urandom();
          it.src_port = $urandom_range(0, 16'hFFFF);
        end
        send_item(it, 0, '0);
      end
      burst = 0;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Covered %0d learn and %0d fan-out transactions, %0d results, %0d evictions,",
             n_learn, n_fanout, n_results, n_evict);
    $display("over five register settings including the age limit extremes.");
    if (n_fail == 0 && pending_q.size() == 0) begin
      $display("peer_learning_table_with_aging_core: match");
    end else begin
      $display("peer_learning_table_with_aging_core: mismatch");
    end
    $finish;
  end
endmodule
